/* rtl/ngas_pkg.sv */
// ---------------------------------------------------------------------------
// ngas_pkg
// Shared constants, types and helpers for the n-gram anomaly scorer.
// ---------------------------------------------------------------------------
package ngas_pkg;

    localparam int BUCKETS  = 1024;
    localparam int WAYS     = 4;
    localparam int MAX_GRAM = 7;
    localparam int SLOTS    = BUCKETS * WAYS;
    localparam int BKT_W    = $clog2(BUCKETS);
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int KEY_W    = 8 * MAX_GRAM;
    localparam int FILL_W   = $clog2(MAX_GRAM + 1);

    localparam logic [2:0]  DEFAULT_GRAM = 3'd3;
    localparam logic [19:0] TEXT_MAX     = 20'hFFFFF;
    localparam logic [31:0] CNT_MAX      = 32'hFFFF_FFFF;
    localparam logic [29:0] LN2_Q30      = 30'd744261118;

    localparam logic [1:0] REG_GRAM_LEN   = 2'd0;
    localparam logic [1:0] REG_SMOOTHING  = 2'd1;
    localparam logic [1:0] REG_SCORE_MODE = 2'd2;

    // work item passed from front to back
    typedef struct packed {
        logic             has_gram;
        logic             last;
        logic [KEY_W-1:0] key;
        logic [BKT_W-1:0] bucket;
        logic             score;
        logic [15:0]      k;
    } t_job;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_LOOK, S_WR, S_LOGN, S_LOGD,
        S_MUL, S_ACC, S_DIV, S_OUT
    } t_state;

endpackage

/* rtl/ngas_log2.sv */
// ---------------------------------------------------------------------------
// ngas_log2
// Iterative log2 in Q.20: normalize over cycles, then 20 squaring steps.
// ---------------------------------------------------------------------------
module ngas_log2 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [26:0] o_log
);
    logic [63:0] r_x;
    logic [5:0]  r_e;
    logic [31:0] r_m;
    logic [19:0] r_frac;
    logic [4:0]  r_cnt;
    logic [1:0]  r_ph;   // 0 idle, 1 normalize, 2 square
    logic        r_done;
    logic [63:0] w_sq;
    logic [32:0] w_m2;

    assign w_sq = {32'd0, r_m} * {32'd0, r_m};
    assign w_m2 = w_sq[62:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_ph)
                2'd0: if (i_start) begin
                    r_x    <= i_x;
                    r_e    <= 6'd63;
                    r_frac <= '0;
                    r_cnt  <= '0;
                    if (i_x == 64'd0) begin
                        r_e    <= 6'd0;
                        r_m    <= 32'h4000_0000;
                        r_cnt  <= 5'd20;
                        r_ph   <= 2'd2;
                    end else begin
                        r_ph <= 2'd1;
                    end
                end
                2'd1: begin
                    if (r_x[63]) begin
                        r_m  <= r_x[63:32] >> 1;
                        r_ph <= 2'd2;
                    end else begin
                        r_x <= r_x << 1;
                        r_e <= r_e - 6'd1;
                    end
                end
                2'd2: begin
                    if (r_cnt == 5'd20) begin
                        r_ph   <= 2'd0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                        if (w_m2[31]) begin
                            r_m    <= w_m2[32:1];
                            r_frac <= {r_frac[18:0], 1'b1};
                        end else begin
                            r_m    <= w_m2[31:0];
                            r_frac <= {r_frac[18:0], 1'b0};
                        end
                    end
                end
                default: r_ph <= 2'd0;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_log  = {1'b0, r_e, r_frac};
endmodule

/* rtl/ngas_front.sv */
// ---------------------------------------------------------------------------
// ngas_front
// Window builder and hasher; pushes one job per accepted byte.
// ---------------------------------------------------------------------------
module ngas_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic              i_enable,
    input  logic [2:0]        i_gram_len,
    input  logic [15:0]       i_smoothing,
    input  logic              i_score_mode,
    output logic              o_push,
    output ngas_pkg::t_job    o_job,
    input  logic              i_full
);
    logic [ngas_pkg::KEY_W-1:0]  r_window, w_win, w_key;
    logic [ngas_pkg::FILL_W-1:0] r_fill, w_fill;
    logic [2:0]                  w_n;
    logic [ngas_pkg::BKT_W-1:0]  w_h;
    logic [ngas_pkg::KEY_W-1:0]  w_mask;

    assign o_ready = i_enable && !i_full;
    assign o_push  = i_valid && o_ready;

    // hash kept to the bucket bits only: the power-of-two bucket count
    // makes the low bits independent of the upper ones
    always_comb begin
        w_n = (i_gram_len == 3'd0) ? ngas_pkg::DEFAULT_GRAM : i_gram_len;
        if (32'(w_n) > ngas_pkg::MAX_GRAM) w_n = 3'(ngas_pkg::MAX_GRAM);
        w_win = {r_window[ngas_pkg::KEY_W-9:0], i_byte};
        w_fill = (32'(r_fill) < ngas_pkg::MAX_GRAM) ? r_fill + 1'b1 : r_fill;
        w_mask = '0;
        for (int j = 0; j < ngas_pkg::MAX_GRAM; j++)
            if (j < 32'(w_n)) w_mask[8*j +: 8] = 8'hFF;
        w_key = w_win & w_mask;
        w_h = ngas_pkg::BKT_W'(32'd5381);
        for (int j = ngas_pkg::MAX_GRAM - 1; j >= 0; j--)
            if (j < 32'(w_n))
                w_h = ngas_pkg::BKT_W'(w_h * ngas_pkg::BKT_W'(33)
                                       + ngas_pkg::BKT_W'(w_win[8*j +: 8]));
    end

    always_comb begin
        o_job.has_gram = (32'(w_fill) >= 32'(w_n));
        o_job.last     = i_last;
        o_job.key      = w_key;
        o_job.bucket   = w_h;
        o_job.score    = i_score_mode;
        o_job.k        = (i_smoothing == 16'd0) ? 16'd1 : i_smoothing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_fill   <= '0;
        end else if (o_push) begin
            if (i_last) begin
                r_window <= '0;
                r_fill   <= '0;
            end else begin
                r_window <= w_win;
                r_fill   <= w_fill;
            end
        end
    end
endmodule

/* rtl/ngas_fifo.sv */
// ---------------------------------------------------------------------------
// ngas_fifo
// Two-entry job queue between front and back.
// ---------------------------------------------------------------------------
module ngas_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ngas_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ngas_pkg::t_job o_job
);
    ngas_pkg::t_job r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

/* rtl/ngas_back.sv */
// ---------------------------------------------------------------------------
// ngas_back
// Bucket table update, log score, mean divide and result register.
// ---------------------------------------------------------------------------
module ngas_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  ngas_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_busy_clear,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [23:0]    o_mean,
    output logic [19:0]    o_grams,
    output logic [12:0]    o_distinct,
    output logic           o_full
);
    ngas_pkg::t_state r_st, n_st;
    ngas_pkg::t_job   r_job;

    // one word per bucket holds all ways: one address per cycle
    logic [ngas_pkg::WAYS-1:0]                       r_vbits [ngas_pkg::BUCKETS];
    logic [ngas_pkg::WAYS-1:0][ngas_pkg::KEY_W-1:0] r_keym  [ngas_pkg::BUCKETS];
    logic [ngas_pkg::WAYS-1:0][31:0]                r_cntm  [ngas_pkg::BUCKETS];
    logic [ngas_pkg::WAYS-1:0][ngas_pkg::KEY_W-1:0] r_rkey;
    logic [ngas_pkg::WAYS-1:0][31:0]                r_rcnt;
    logic [ngas_pkg::WAYS-1:0]                       r_rv;

    logic [ngas_pkg::BKT_W:0]   r_clr;
    logic [31:0]                r_total;
    logic [12:0]                r_distinct;
    logic signed [47:0]         r_sum;
    logic [19:0]                r_tg;
    logic                       r_ovf;
    logic                       r_hit_ok, r_free_ok;
    logic [ngas_pkg::WAY_W-1:0] r_way;
    logic [31:0]                r_c;
    logic [26:0]                r_la;
    logic [56:0]                r_prod;
    logic [47:0]                r_mag, r_rem;
    logic [5:0]                 r_dcnt;
    logic [47:0]                r_q;

    logic                       w_hit, w_free, w_gram;
    logic [ngas_pkg::WAY_W-1:0] w_hw, w_fw;
    logic                       l_start, l_done;
    logic [63:0]                l_x;
    logic [26:0]                l_log;
    logic [48:0]                w_rs;

    ngas_log2 u_log (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(l_start), .i_x(l_x),
        .o_done(l_done), .o_log(l_log)
    );

    // gram counts only below the per-text limit
    assign w_gram = r_job.has_gram && (r_tg != ngas_pkg::TEXT_MAX);

    always_comb begin
        w_hit = 1'b0; w_free = 1'b0; w_hw = '0; w_fw = '0;
        for (int w = 0; w < ngas_pkg::WAYS; w++) begin
            if (r_rv[w]) begin
                if (!w_hit && r_rkey[w] == r_job.key) begin
                    w_hit = 1'b1; w_hw = ngas_pkg::WAY_W'(w);
                end
            end else if (!w_free) begin
                w_free = 1'b1; w_fw = ngas_pkg::WAY_W'(w);
            end
        end
    end

    always_comb begin
        n_st    = r_st;
        o_pop   = 1'b0;
        l_start = 1'b0;
        l_x     = {20'd0, r_c, 12'd0} + {48'd0, r_job.k};
        case (r_st)
            // denominator pass is started when the numerator pass ends
            ngas_pkg::S_LOGN: l_x = {20'd0, r_total, 12'd0}
                                 + {35'd0, 16'(r_job.k) * 29'(r_distinct)};
            default: ;
        endcase
        unique case (r_st)
            ngas_pkg::S_CLEAR: if (r_clr[ngas_pkg::BKT_W]) n_st = ngas_pkg::S_IDLE;
            ngas_pkg::S_IDLE: if (!i_empty) begin
                o_pop = 1'b1;
                n_st  = ngas_pkg::S_RD;
            end
            ngas_pkg::S_RD: n_st = ngas_pkg::S_LOOK;
            ngas_pkg::S_LOOK: begin
                if (!w_gram) n_st = r_job.last ? ngas_pkg::S_DIV : ngas_pkg::S_IDLE;
                else n_st = ngas_pkg::S_WR;
            end
            ngas_pkg::S_WR: begin
                if (r_job.score && r_total != 32'd0) begin
                    l_start = 1'b1; n_st = ngas_pkg::S_LOGN;
                end else n_st = r_job.last ? ngas_pkg::S_DIV : ngas_pkg::S_IDLE;
            end
            ngas_pkg::S_LOGN: if (l_done) begin
                l_start = 1'b1; n_st = ngas_pkg::S_LOGD;
            end
            ngas_pkg::S_LOGD: if (l_done) n_st = ngas_pkg::S_MUL;
            ngas_pkg::S_MUL:  n_st = ngas_pkg::S_ACC;
            ngas_pkg::S_ACC:  n_st = r_job.last ? ngas_pkg::S_DIV : ngas_pkg::S_IDLE;
            ngas_pkg::S_DIV:  if (r_dcnt == 6'd49) n_st = ngas_pkg::S_OUT;
            ngas_pkg::S_OUT:  if (i_ready) n_st = ngas_pkg::S_IDLE;
            default: n_st = ngas_pkg::S_IDLE;
        endcase
    end

    assign w_rs = {r_rem, r_mag[47]};

    // memories
    always_ff @(posedge i_clk) begin
        if (r_st == ngas_pkg::S_RD) begin
            r_rkey <= r_keym[r_job.bucket];
            r_rcnt <= r_cntm[r_job.bucket];
        end
        if (r_st == ngas_pkg::S_WR && !r_job.score && r_hit_ok) begin
            if (r_c != ngas_pkg::CNT_MAX) r_cntm[r_job.bucket][r_way] <= r_c + 32'd1;
        end else if (r_st == ngas_pkg::S_WR && !r_job.score && r_free_ok) begin
            r_keym[r_job.bucket][r_way] <= r_job.key;
            r_cntm[r_job.bucket][r_way] <= 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ngas_pkg::S_CLEAR)
            r_vbits[r_clr[ngas_pkg::BKT_W-1:0]] <= '0;
        else if (r_st == ngas_pkg::S_WR && !r_job.score && !r_hit_ok && r_free_ok)
            r_vbits[r_job.bucket][r_way] <= 1'b1;
        if (r_st == ngas_pkg::S_RD) r_rv <= r_vbits[r_job.bucket];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ngas_pkg::S_CLEAR; r_clr <= '0;
            r_total <= '0; r_distinct <= '0; r_sum <= '0; r_tg <= '0; r_ovf <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ngas_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
            if (o_pop) r_job <= i_job;
            if (r_st == ngas_pkg::S_LOOK) begin
                r_hit_ok  <= w_hit;
                r_free_ok <= w_free;
                r_way     <= w_hit ? w_hw : w_fw;
                r_c       <= w_hit ? r_rcnt[w_hw] : 32'd0;
                if (w_gram) r_tg <= r_tg + 20'd1;
            end
            if (r_st == ngas_pkg::S_WR && !r_job.score) begin
                if (r_hit_ok || r_free_ok) begin
                    if (r_total != ngas_pkg::CNT_MAX) r_total <= r_total + 32'd1;
                    if (!r_hit_ok) r_distinct <= r_distinct + 13'd1;
                end else r_ovf <= 1'b1;
            end
            if (r_st == ngas_pkg::S_LOGN && l_done) r_la <= l_log;
            if (r_st == ngas_pkg::S_LOGD && l_done)
                r_prod <= (r_la >= l_log) ? 57'd0 : 27'(l_log - r_la) * ngas_pkg::LN2_Q30;
            if (r_st == ngas_pkg::S_MUL) r_sum <= r_sum - 48'((r_prod + 57'h2_0000_0000) >> 34);
            if (n_st == ngas_pkg::S_DIV && r_st != ngas_pkg::S_DIV) begin
                r_dcnt <= '0;
            end
            if (r_st == ngas_pkg::S_DIV) begin
                if (r_dcnt == 6'd0) begin
                    r_mag <= 48'(-r_sum) + {29'd0, r_tg[19:1]};
                    r_rem <= '0; r_q <= '0;
                end else if (r_dcnt < 6'd49) begin
                    r_mag <= r_mag << 1;
                    if (w_rs >= {29'd0, r_tg}) begin
                        r_rem <= 48'(w_rs - {29'd0, r_tg}); r_q <= {r_q[46:0], 1'b1};
                    end else begin
                        r_rem <= w_rs[47:0]; r_q <= {r_q[46:0], 1'b0};
                    end
                end
                r_dcnt <= r_dcnt + 6'd1;
            end
            if (r_st == ngas_pkg::S_OUT && i_ready) begin
                r_sum <= '0; r_tg <= '0;
            end
        end
    end

    assign o_busy_clear = (r_st == ngas_pkg::S_CLEAR);
    assign o_valid      = (r_st == ngas_pkg::S_OUT);
    assign o_mean       = (r_job.score && r_tg != 20'd0 && r_total != 32'd0)
                          ? 24'(-r_q) : 24'd0;
    assign o_grams      = r_tg;
    assign o_distinct   = r_distinct;
    assign o_full       = r_ovf;
endmodule

/* rtl/ngram_anomaly_scorer_top.sv */
// ---------------------------------------------------------------------------
// ngram_anomaly_scorer_top
// Character n-gram counter / Laplace-smoothed log-likelihood scorer.
// ---------------------------------------------------------------------------
// channel  dir  handshake                 payload
// s_axis   in   s_axis_tvalid/tready      tdata = text_byte, tlast = last
// m_axis   out  m_axis_tvalid/tready      tdata = mean, grams, distinct, full
// cfg      in   i_cfg_we                  idx 0 gram_len, 1 smoothing, 2 mode
//
// Sequence: a byte without a gram passes the back states pop, read, lookup;
// a train gram adds a write; a score gram adds the write, two serial log2
// passes (numerator, then denominator), each of normalize steps until the
// operand's leading bit is found, squaring steps and a done step, then
// multiply and accumulate. A last byte adds a restoring divide for the mean and an output state held until taken.
// Reset: clear sweep over bucket valid bits; no input taken then.
// Stalls: a two-entry queue lets the front take bytes while the back works.
// ---------------------------------------------------------------------------
module ngram_anomaly_scorer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [23:0] mean, [43:24] grams,
                                        // [56:44] distinct, [57] table_full
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    logic [2:0]  r_gram_len;
    logic [15:0] r_smoothing;
    logic        r_score_mode;

    logic           w_push, w_full, w_pop, w_empty, w_clear;
    ngas_pkg::t_job w_job_in, w_job_out;
    logic [23:0]    w_mean;
    logic [19:0]    w_grams;
    logic [12:0]    w_distinct;
    logic           w_tfull;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gram_len <= 3'd3; r_smoothing <= 16'd4096; r_score_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ngas_pkg::REG_GRAM_LEN:   r_gram_len   <= i_cfg_data[2:0];
                ngas_pkg::REG_SMOOTHING:  r_smoothing  <= i_cfg_data;
                ngas_pkg::REG_SCORE_MODE: r_score_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // front holds off only during the clear sweep and when the queue is full;
    // the per-text gram limit is applied in the back end
    ngas_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_last(s_axis_tlast),
        .i_enable(!w_clear),
        .i_gram_len(r_gram_len), .i_smoothing(r_smoothing),
        .i_score_mode(r_score_mode),
        .o_push(w_push), .o_job(w_job_in), .i_full(w_full)
    );

    ngas_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_job(w_job_in), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_job(w_job_out)
    );

    ngas_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(w_empty), .i_job(w_job_out), .o_pop(w_pop),
        .o_busy_clear(w_clear),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_mean(w_mean), .o_grams(w_grams), .o_distinct(w_distinct),
        .o_full(w_tfull)
    );

    assign m_axis_tdata = {6'd0, w_tfull, w_distinct, w_grams, w_mean};

    ap_no_push_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |-> !w_push) else $error("push during clear");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped");
endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the n-gram anomaly scorer. A queue of text bytes
// feeds a clocked driver; every accepted byte is run through a local copy of
// the hashed gram table and the log-likelihood arithmetic, and each result
// beat is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDLE_PCT   = 38;
    localparam int DRAIN_WAIT = 1000;  // up to three score grams in flight
    localparam int WDOG_LIMIT = 8000;  // covers the clear sweep

    typedef struct {
        logic [7:0] text_byte;
        logic       last;
    } t_text_beat;

    typedef struct {
        logic [23:0] mean;
        logic [19:0] grams;
        logic [12:0] distinct;
        logic        full;
    } t_score;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    ngram_anomaly_scorer_top DUT (.*);

    // ---- scoreboard state ----
    t_text_beat byte_queue[$];
    t_score     score_queue[$];
    int         errors;
    int         cycle_cnt;
    int         stall_cnt;
    logic       in_taken;

    // ---- local copy of the scorer ----
    logic [2:0]                 mdl_gram_len;
    logic [15:0]                mdl_k;
    logic                       mdl_score;
    logic [ngas_pkg::KEY_W-1:0] mdl_window;
    int unsigned                mdl_fill;
    logic                       tbl_valid [ngas_pkg::SLOTS];
    logic [ngas_pkg::KEY_W-1:0] tbl_key [ngas_pkg::SLOTS];
    logic [31:0]                tbl_count [ngas_pkg::SLOTS];
    logic [31:0]                mdl_total;
    int unsigned                mdl_distinct;
    longint                     mdl_log_sum;
    int unsigned                mdl_text_grams;
    logic                       mdl_full;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned log2_q20(longint unsigned x);
        int unsigned     e;
        longint unsigned m;
        longint unsigned frac;
        frac = 0;
        if (x == 0) return 0;
        e = 63;
        while (x[e] == 1'b0) e--;
        m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
        for (int i = 0; i < 20; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(e) << 20) | frac;
    endfunction

    function automatic int unsigned bucket_of(logic [ngas_pkg::KEY_W-1:0] key,
                                              int unsigned n);
        logic [31:0] h;
        h = 32'd5381;
        for (int j = n; j > 0; j--) h = h * 33 + key[8*(j-1) +: 8];
        return h % ngas_pkg::BUCKETS;
    endfunction

    // Advance the model by one text byte; queue a result on a last byte.
    task automatic score_byte(logic [7:0] b, logic last);
        int unsigned                n;
        longint unsigned            k;
        logic [ngas_pkg::KEY_W-1:0] key;
        int unsigned                base;
        int                         hit;
        int                         free_way;
        longint unsigned            c;
        longint unsigned            la;
        longint unsigned            lb;
        longint unsigned            mag;
        longint                     mean;
        t_score                     res;
        n = (mdl_gram_len == 0) ? ngas_pkg::DEFAULT_GRAM : mdl_gram_len;
        k = (mdl_k == 0) ? 1 : mdl_k;
        mdl_window = {mdl_window[ngas_pkg::KEY_W-9:0], b};
        if (mdl_fill < ngas_pkg::MAX_GRAM) mdl_fill++;
        if (mdl_fill >= n && mdl_text_grams < ngas_pkg::TEXT_MAX) begin
            key = '0;
            for (int j = 0; j < n; j++) key[8*j +: 8] = mdl_window[8*j +: 8];
            base = bucket_of(key, n) * ngas_pkg::WAYS;
            hit = -1;
            free_way = -1;
            for (int w = 0; w < ngas_pkg::WAYS; w++) begin
                if (tbl_valid[base+w]) begin
                    if (hit < 0 && tbl_key[base+w] == key) hit = w;
                end else if (free_way < 0) begin
                    free_way = w;
                end
            end
            mdl_text_grams++;
            if (!mdl_score) begin
                if (hit >= 0) begin
                    if (tbl_count[base+hit] != ngas_pkg::CNT_MAX) tbl_count[base+hit]++;
                    if (mdl_total != ngas_pkg::CNT_MAX) mdl_total++;
                end else if (free_way >= 0) begin
                    tbl_valid[base+free_way] = 1'b1;
                    tbl_key[base+free_way]   = key;
                    tbl_count[base+free_way] = 32'd1;
                    if (mdl_total != ngas_pkg::CNT_MAX) mdl_total++;
                    mdl_distinct++;
                end else begin
                    mdl_full = 1'b1;   // bucket full, gram dropped
                end
            end else if (mdl_total != 0) begin
                c  = (hit >= 0) ? tbl_count[base+hit] : 0;
                la = log2_q20(c * 4096 + k);
                lb = log2_q20(longint'(mdl_total) * 4096 + k * mdl_distinct);
                if (la < lb)
                    mdl_log_sum -= longint'(((lb - la) * longint'(ngas_pkg::LN2_Q30)
                                             + (64'd1 << 33)) >> 34);
            end
        end
        if (last) begin
            mean = 0;
            if (mdl_score && mdl_text_grams != 0 && mdl_total != 0) begin
                mag  = -mdl_log_sum;
                mean = -longint'((mag + mdl_text_grams / 2) / mdl_text_grams);
            end
            res.mean     = mean[23:0];
            res.grams    = mdl_text_grams[19:0];
            res.distinct = (mdl_distinct > 8191) ? 13'd8191 : mdl_distinct[12:0];
            res.full     = mdl_full;
            score_queue.push_back(res);
            mdl_window = '0;
            mdl_fill = 0;
            mdl_log_sum = 0;
            mdl_text_grams = 0;
        end
    endtask

    // ---- input driver: changes at the falling edge ----
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            // idle-free stretch in the middle of the run
            if (!s_axis_tvalid || in_taken) begin
                if (byte_queue.size() != 0 &&
                    ((cycle_cnt > 30000 && cycle_cnt < 38000) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= byte_queue[0].text_byte;
                    s_axis_tlast  <= byte_queue[0].last;
                    void'(byte_queue.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= (cycle_cnt > 30000 && cycle_cnt < 38000) ||
                             ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---- monitor: sample at the rising edge ----
    always @(posedge i_clk) begin
        t_score exp_res;
        cycle_cnt <= cycle_cnt + 1;
        in_taken  <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready) score_byte(s_axis_tdata, s_axis_tlast);
        if (m_axis_tvalid && m_axis_tready) begin
            if (score_queue.size() == 0) begin
                $display("%0t: unexpected result beat, actual %h", $time, m_axis_tdata);
                errors++;
            end else begin
                exp_res = score_queue.pop_front();
                if (m_axis_tdata[23:0] !== exp_res.mean) begin
                    $display("%0t: mean_log_prob expected %h actual %h",
                             $time, exp_res.mean, m_axis_tdata[23:0]);
                    errors++;
                end
                if (m_axis_tdata[43:24] !== exp_res.grams) begin
                    $display("%0t: grams_in_text expected %0d actual %0d",
                             $time, exp_res.grams, m_axis_tdata[43:24]);
                    errors++;
                end
                if (m_axis_tdata[56:44] !== exp_res.distinct) begin
                    $display("%0t: distinct_grams expected %0d actual %0d",
                             $time, exp_res.distinct, m_axis_tdata[56:44]);
                    errors++;
                end
                if (m_axis_tdata[57] !== exp_res.full) begin
                    $display("%0t: table_full expected %b actual %b",
                             $time, exp_res.full, m_axis_tdata[57]);
                    errors++;
                end
            end
        end
    end

    // ---- watchdog: cycles without any beat ----
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        case (idx)
            ngas_pkg::REG_GRAM_LEN:   mdl_gram_len = value[2:0];
            ngas_pkg::REG_SMOOTHING:  mdl_k        = value;
            ngas_pkg::REG_SCORE_MODE: mdl_score    = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_config(logic [2:0] n, logic [15:0] k, logic mode);
        write_reg(ngas_pkg::REG_GRAM_LEN, {13'd0, n});
        write_reg(ngas_pkg::REG_SMOOTHING, k);
        write_reg(ngas_pkg::REG_SCORE_MODE, {15'd0, mode});
    endtask

    // wait for every queued byte and result, then let the back end settle
    task automatic drain();
        while (byte_queue.size() != 0 || s_axis_tvalid || score_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // push one text; small alphabets make repeated grams likely
    task automatic push_text(int len, bit narrow, bit terminate);
        t_text_beat tb;
        for (int i = 0; i < len; i++) begin
            tb.text_byte = narrow ? 8'(97 + $urandom_range(4)) : 8'($urandom_range(255, 1));
            tb.last = terminate && (i == len - 1);
            byte_queue.push_back(tb);
        end
    endtask

    task automatic push_byte(logic [7:0] b, logic last);
        t_text_beat tb;
        tb.text_byte = b;
        tb.last = last;
        byte_queue.push_back(tb);
    endtask

    initial begin
        int       sent;
        int       len;
        bit [2:0] n;
        bit [15:0] k;
        errors = 0;
        cycle_cnt = 0;
        stall_cnt = 0;
        in_taken = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = ngas_pkg::REG_GRAM_LEN;
        i_cfg_data = '0;
        mdl_gram_len = ngas_pkg::DEFAULT_GRAM;
        mdl_k = 16'd4096;
        mdl_score = 1'b0;
        mdl_window = '0;
        mdl_fill = 0;
        mdl_total = '0;
        mdl_distinct = 0;
        mdl_log_sum = 0;
        mdl_text_grams = 0;
        mdl_full = 1'b0;
        for (int s = 0; s < ngas_pkg::SLOTS; s++) tbl_valid[s] = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed part ----
        // scoring an empty model
        set_config(3'd3, 16'd4096, 1'b1);
        push_byte(8'd1, 0); push_byte(8'd255, 0); push_byte(8'd0, 0); push_byte(8'd7, 1);
        drain();
        // colliding 2-byte grams fill one bucket and overflow it
        set_config(3'd2, 16'd4096, 1'b0);
        for (int i = 0; i < 5; i++) begin
            push_byte(8'(10 + i), 0);
            push_byte(8'(200 - 33 * i), 1);
        end
        // text shorter than the gram
        push_byte(8'd255, 1);
        drain();
        // gram length zero falls back to three, smoothing zero to one
        set_config(3'd0, 16'd0, 1'b1);
        push_byte(8'd10, 0); push_byte(8'd200, 0); push_byte(8'd11, 1);
        drain();
        // longest gram, largest smoothing, mode change in the middle of a text
        set_config(3'd7, 16'hFFFF, 1'b0);
        for (int i = 0; i < 5; i++) push_byte(8'(97 + i), 0);
        drain();
        write_reg(ngas_pkg::REG_SCORE_MODE, 16'd1);
        for (int i = 0; i < 5; i++) push_byte(8'(97 + i), i == 4);
        drain();

        // ---- random part ----
        sent = 0;
        for (int p = 0; sent < 1200; p++) begin
            n = (p % 5 == 0) ? 3'd7 : (p % 5 == 1) ? 3'd0 : 3'($urandom_range(7));
            k = (p % 4 == 0) ? 16'hFFFF : (p % 4 == 1) ? 16'd1 : 16'($urandom);
            set_config(n, k, p[0]);
            for (int t = 0; t < 14; t++) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                               : $urandom_range(12, 1);
                push_text(len, $urandom_range(4) != 0, 1'b1);
                sent += len;
            end
            // leave a text open across the next mode change now and then
            if ($urandom_range(2) == 0) begin
                len = $urandom_range(6, 1);
                push_text(len, 1'b1, 1'b0);
                sent += len;
            end
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
